[hdl/mono_page_framebuffer_draw_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the monochrome page framebuffer draw unit.
// Each macro builds one labeled concurrent assertion that reports through $error.
// ----------------------------------------------------------------------------
`ifndef MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_ASSERT_SVH
`define MONO_PAGE_FRAMEBUFFER_DRAW_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPFB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/mpfb_pkg.sv]
// ----------------------------------------------------------------------------
// mpfb_pkg
// Shared constants, types and segment decode functions for the framebuffer
// draw unit.
// ----------------------------------------------------------------------------
package mpfb_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
   localparam int COL_BITS       = $clog2(DISPLAY_WIDTH);
   localparam int PAGE_BITS      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int ADDR_BITS      = PAGE_BITS + COL_BITS;
   localparam int SEG_BITS       = 5;

   localparam logic [7:0] ROUND_THICK = 8'd2;

   localparam logic [2:0] CMD_SET   = 3'd0;
   localparam logic [2:0] CMD_GET   = 3'd1;
   localparam logic [2:0] CMD_HLINE = 3'd2;
   localparam logic [2:0] CMD_VLINE = 3'd3;
   localparam logic [2:0] CMD_RECT  = 3'd4;
   localparam logic [2:0] CMD_ROUND = 3'd5;

   typedef struct packed {
      logic [2:0] code;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] w;
      logic [7:0] h;
      logic       ink;
      logic       erase;
   } draw_cmd_type;

   typedef struct packed {
      logic [7:0] x0;
      logic [7:0] y0;
      logic [7:0] len;
      logic [7:0] thick;
      logic       vert;
      logic       val;
   } seg_type;

   typedef struct packed {
      logic clear_wr;
      logic accept;
      logic load_seg;
      logic pix_rd;
      logic pix_wr;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic seg_end;
      logic seg_empty;
      logic pix_last;
      logic is_get;
   } dp_status_type;

   function automatic seg_type mk_seg(logic [7:0] x0, logic [7:0] y0, logic [7:0] len,
                                      logic [7:0] thick, logic vert, logic val);
      seg_type s;
      s.x0    = x0;
      s.y0    = y0;
      s.len   = len;
      s.thick = thick;
      s.vert  = vert;
      s.val   = val;
      return s;
   endfunction

   function automatic logic [SEG_BITS-1:0] seg_count(logic [2:0] code);
      logic [SEG_BITS-1:0] n;
      unique case (code)
         CMD_SET, CMD_GET, CMD_HLINE, CMD_VLINE: n = SEG_BITS'(1);
         CMD_RECT:  n = SEG_BITS'(4);
         CMD_ROUND: n = SEG_BITS'(20);
         default:   n = '0;
      endcase
      return n;
   endfunction

   function automatic seg_type seg_decode(draw_cmd_type cmd, logic [SEG_BITS-1:0] idx);
      seg_type    s;
      logic [7:0] xr1;
      logic [7:0] xr2;
      logic [7:0] xr3;
      logic [7:0] yb1;
      logic [7:0] yb2;
      logic [7:0] yb3;
      logic [7:0] x1;
      logic [7:0] x2;
      logic [7:0] y1;
      logic [7:0] y2;
      logic       v;
      logic       cv;
      xr1 = cmd.x + cmd.w - 8'd1;
      xr2 = cmd.x + cmd.w - ROUND_THICK;
      xr3 = cmd.x + cmd.w - 8'd3;
      yb1 = cmd.y + cmd.h - 8'd1;
      yb2 = cmd.y + cmd.h - ROUND_THICK;
      yb3 = cmd.y + cmd.h - 8'd3;
      x1  = cmd.x + 8'd1;
      x2  = cmd.x + ROUND_THICK;
      y1  = cmd.y + 8'd1;
      y2  = cmd.y + ROUND_THICK;
      v   = cmd.ink;
      cv  = cmd.erase ? cmd.ink : ~cmd.ink;
      s   = mk_seg(cmd.x, cmd.y, 8'd0, 8'd0, 1'b0, v);
      unique case (cmd.code)
         CMD_SET, CMD_GET: s = mk_seg(cmd.x, cmd.y, 8'd1, 8'd1, 1'b0, v);
         CMD_HLINE: s = mk_seg(cmd.x, cmd.y, cmd.w, cmd.h, 1'b0, v);
         CMD_VLINE: s = mk_seg(cmd.x, cmd.y, cmd.w, cmd.h, 1'b1, v);
         CMD_RECT: begin
            unique case (idx)
               SEG_BITS'(0): s = mk_seg(cmd.x, cmd.y, cmd.w, 8'd1, 1'b0, v);
               SEG_BITS'(1): s = mk_seg(cmd.x, yb1, cmd.w, 8'd1, 1'b0, v);
               SEG_BITS'(2): s = mk_seg(cmd.x, y1, cmd.h - 8'd2, 8'd1, 1'b1, v);
               SEG_BITS'(3): s = mk_seg(xr1, y1, cmd.h - 8'd2, 8'd1, 1'b1, v);
               default:      s = mk_seg(cmd.x, cmd.y, 8'd0, 8'd0, 1'b0, v);
            endcase
         end
         CMD_ROUND: begin
            unique case (idx)
               SEG_BITS'(0):  s = mk_seg(cmd.x, cmd.y, cmd.w, ROUND_THICK, 1'b0, v);
               SEG_BITS'(1):  s = mk_seg(cmd.x, yb2, cmd.w, ROUND_THICK, 1'b0, v);
               SEG_BITS'(2):  s = mk_seg(cmd.x, y2, cmd.h - 8'd4, ROUND_THICK, 1'b1, v);
               SEG_BITS'(3):  s = mk_seg(xr2, y2, cmd.h - 8'd4, ROUND_THICK, 1'b1, v);
               SEG_BITS'(4):  s = mk_seg(cmd.x, cmd.y, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(5):  s = mk_seg(x1, cmd.y, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(6):  s = mk_seg(cmd.x, y1, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(7):  s = mk_seg(x2, y2, 8'd1, 8'd1, 1'b0, v);
               SEG_BITS'(8):  s = mk_seg(xr1, cmd.y, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(9):  s = mk_seg(xr2, cmd.y, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(10): s = mk_seg(xr1, y1, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(11): s = mk_seg(xr3, y2, 8'd1, 8'd1, 1'b0, v);
               SEG_BITS'(12): s = mk_seg(xr1, yb1, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(13): s = mk_seg(xr2, yb1, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(14): s = mk_seg(xr1, yb2, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(15): s = mk_seg(xr3, yb3, 8'd1, 8'd1, 1'b0, v);
               SEG_BITS'(16): s = mk_seg(cmd.x, yb1, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(17): s = mk_seg(x1, yb1, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(18): s = mk_seg(cmd.x, yb2, 8'd1, 8'd1, 1'b0, cv);
               SEG_BITS'(19): s = mk_seg(x2, yb3, 8'd1, 8'd1, 1'b0, v);
               default:       s = mk_seg(cmd.x, cmd.y, 8'd0, 8'd0, 1'b0, v);
            endcase
         end
         default: s = mk_seg(cmd.x, cmd.y, 8'd0, 8'd0, 1'b0, v);
      endcase
      return s;
   endfunction

endpackage

[hdl/mpfb_ifs.sv]
// ----------------------------------------------------------------------------
// mpfb channel interfaces
// Valid/ready channels for draw requests and draw responses.
// ----------------------------------------------------------------------------
interface mpfb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [7:0] x_pos;
   logic [7:0] y_pos;
   logic [7:0] span_main;
   logic [7:0] span_cross;
   logic       ink;
   logic       corner_erase;

   modport source (output valid, req_type, x_pos, y_pos, span_main, span_cross, ink,
                   corner_erase, input ready);
   modport sink (input valid, req_type, x_pos, y_pos, span_main, span_cross, ink,
                 corner_erase, output ready);
endinterface

interface mpfb_rsp_if;
   logic valid;
   logic ready;
   logic pixel_value;

   modport source (output valid, pixel_value, input ready);
   modport sink (input valid, pixel_value, output ready);
endinterface

[hdl/mpfb_datapath.sv]
// ----------------------------------------------------------------------------
// mpfb_datapath
// Command and segment registers, pixel walk counters, clipping, and the
// page-organized framebuffer memory with its read-modify-write path.
// ----------------------------------------------------------------------------
module mpfb_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  mpfb_pkg::draw_cmd_type req_cmd,
   input  mpfb_pkg::ctl_cmd_type  ctl,
   output mpfb_pkg::dp_status_type status,
   output logic                   pixel_value
);

   logic [7:0] mem [2**mpfb_pkg::ADDR_BITS];

   logic [mpfb_pkg::ADDR_BITS-1:0] clr_ff, clr_in;
   mpfb_pkg::draw_cmd_type         cmd_ff, cmd_in;
   logic [mpfb_pkg::SEG_BITS-1:0]  seg_idx_ff, seg_idx_in;
   mpfb_pkg::seg_type              seg_ff, seg_in;
   logic [7:0]                     i_ff, i_in;
   logic [7:0]                     j_ff, j_in;
   logic [7:0]                     rd_byte_ff;
   logic                           pixel_value_ff, pixel_value_in;

   logic [7:0]                     px;
   logic [7:0]                     py;
   logic                           in_range;
   logic [mpfb_pkg::ADDR_BITS-1:0] pix_addr;
   logic [mpfb_pkg::ADDR_BITS-1:0] waddr;
   logic [7:0]                     bit_mask;
   logic [7:0]                     wdata;
   logic                           we;
   logic                           j_last;
   logic                           i_last;

   always_comb begin
      px       = seg_ff.x0 + (seg_ff.vert ? j_ff : i_ff);
      py       = seg_ff.y0 + (seg_ff.vert ? i_ff : j_ff);
      in_range = ({1'b0, px} < 9'(mpfb_pkg::DISPLAY_WIDTH)) &&
                 ({1'b0, py} < 9'(mpfb_pkg::DISPLAY_HEIGHT));
      pix_addr = {py[3 +: mpfb_pkg::PAGE_BITS], px[mpfb_pkg::COL_BITS-1:0]};
      bit_mask = 8'd1 << py[2:0];
      j_last   = (j_ff == seg_ff.thick - 8'd1);
      i_last   = (i_ff == seg_ff.len - 8'd1);

      we    = ctl.clear_wr | (ctl.pix_wr & in_range);
      waddr = ctl.clear_wr ? clr_ff : pix_addr;
      if (ctl.clear_wr) begin
         wdata = 8'd0;
      end else if (seg_ff.val) begin
         wdata = rd_byte_ff | bit_mask;
      end else begin
         wdata = rd_byte_ff & ~bit_mask;
      end

      clr_in     = ctl.clear_wr ? clr_ff + mpfb_pkg::ADDR_BITS'(1) : clr_ff;
      cmd_in     = ctl.accept ? req_cmd : cmd_ff;
      seg_idx_in = seg_idx_ff;
      if (ctl.accept) begin
         seg_idx_in = '0;
      end else if (ctl.load_seg) begin
         seg_idx_in = seg_idx_ff + mpfb_pkg::SEG_BITS'(1);
      end

      seg_in = seg_ff;
      i_in   = i_ff;
      j_in   = j_ff;
      if (ctl.load_seg) begin
         seg_in = mpfb_pkg::seg_decode(cmd_ff, seg_idx_ff);
         i_in   = 8'd0;
         j_in   = 8'd0;
      end else if (ctl.pix_wr) begin
         if (j_last) begin
            j_in = 8'd0;
            i_in = i_ff + 8'd1;
         end else begin
            j_in = j_ff + 8'd1;
         end
      end

      pixel_value_in = (cmd_ff.code == mpfb_pkg::CMD_GET) & in_range & rd_byte_ff[py[2:0]];

      status.clear_last = &clr_ff;
      status.seg_end    = (seg_idx_ff == mpfb_pkg::seg_count(cmd_ff.code));
      status.seg_empty  = (seg_ff.len == 8'd0) || (seg_ff.thick == 8'd0);
      status.pix_last   = i_last & j_last;
      status.is_get     = (cmd_ff.code == mpfb_pkg::CMD_GET);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      cmd_ff     <= cmd_in;
      seg_idx_ff <= seg_idx_in;
      seg_ff     <= seg_in;
      i_ff       <= i_in;
      j_ff       <= j_in;
      if (ctl.load_rsp) begin
         pixel_value_ff <= pixel_value_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (ctl.pix_rd) begin
         rd_byte_ff <= mem[pix_addr];
      end
   end

   assign pixel_value = pixel_value_ff;

endmodule

[hdl/mpfb_controller.sv]
// ----------------------------------------------------------------------------
// mpfb_controller
// Sequencer for the draw unit: framebuffer clearing after reset, command
// intake, segment and pixel stepping, and the response register handshake.
// ----------------------------------------------------------------------------
module mpfb_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  mpfb_pkg::dp_status_type status,
   output mpfb_pkg::ctl_cmd_type   ctl
);

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_SEG   = 7'b0000100,
      ST_CHECK = 7'b0001000,
      ST_READ  = 7'b0010000,
      ST_WRITE = 7'b0100000,
      ST_DONE  = 7'b1000000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      ctl       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_wr = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.accept = 1'b1;
               state_in   = ST_SEG;
            end
         end
         ST_SEG: begin
            if (status.seg_end) begin
               state_in = ST_DONE;
            end else begin
               ctl.load_seg = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.seg_empty ? ST_SEG : ST_READ;
         end
         ST_READ: begin
            ctl.pix_rd = 1'b1;
            state_in   = status.is_get ? ST_DONE : ST_WRITE;
         end
         ST_WRITE: begin
            ctl.pix_wr = 1'b1;
            state_in   = status.pix_last ? ST_SEG : ST_READ;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctl.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/mono_page_framebuffer_draw_unit.sv]
// Sequence: a command's segments are loaded in turn and empty ones are skipped; each pixel
// is a read-modify-write of one byte through the single framebuffer memory, a get only reads,
// and every command ends with one response beat. The unit takes one command at a time and
// accepts no new request beat until that beat is registered, longer while an earlier beat waits.
// Reset: a clearing pass writes every framebuffer byte to zero, one byte per cycle
// (1024 bytes at the default size), and no request beat is accepted until it ends.
// ----------------------------------------------------------------------------
// mono_page_framebuffer_draw_unit
// Drawing engine over a one-bit-per-pixel, page-organized framebuffer:
// set and get pixel, thick lines, rectangle outlines and rounded rectangles.
// ----------------------------------------------------------------------------
module mono_page_framebuffer_draw_unit (
   input logic        clock,
   input logic        reset,
   mpfb_req_if.sink   req_chan,
   mpfb_rsp_if.source rsp_chan
);

   mpfb_pkg::draw_cmd_type  req_cmd;
   mpfb_pkg::ctl_cmd_type   ctl;
   mpfb_pkg::dp_status_type status;

   always_comb begin
      req_cmd.code  = req_chan.req_type;
      req_cmd.x     = req_chan.x_pos;
      req_cmd.y     = req_chan.y_pos;
      req_cmd.w     = req_chan.span_main;
      req_cmd.h     = req_chan.span_cross;
      req_cmd.ink   = req_chan.ink;
      req_cmd.erase = req_chan.corner_erase;
   end

   mpfb_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .status    (status),
      .ctl       (ctl)
   );

   mpfb_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_cmd     (req_cmd),
      .ctl         (ctl),
      .status      (status),
      .pixel_value (rsp_chan.pixel_value)
   );

endmodule

[hdl/mpfb_checker.sv]
// ----------------------------------------------------------------------------
// mpfb_checker
// Port-level assertions for the framebuffer draw unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "mono_page_framebuffer_draw_unit_assert.svh"

module mpfb_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pixel_value
);

   `MPFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_pixel_value), "Stalled response beat changed.")
   `MPFB_ASSERT_SAME(a_clear_blocks, clock, reset, $fell(reset), !req_ready,
      "Request accepted during the clearing pass.")
   `MPFB_ASSERT_NEXT(a_one_in_work, clock, reset, req_valid && req_ready, !req_ready,
      "Request accepted while a command is in work.")
   `MPFB_ASSERT_SAME(a_no_rsp_in_clear, clock, reset, $fell(reset), !rsp_valid,
      "Response beat offered during the clearing pass.")

endmodule

bind mono_page_framebuffer_draw_unit mpfb_checker u_mpfb_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_pixel_value (rsp_chan.pixel_value)
);

[bench/draw_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Draw result checker
// Watches the request and response channels of the framebuffer draw unit.
// It keeps its own copy of the framebuffer and applies every accepted command
// to it. It then compares each response beat with the pixel value that the
// copy predicts, in command order.
// ----------------------------------------------------------------------------
module draw_result_checker (
   input  logic clock,
   input  logic reset,
   mpfb_req_if  req_chan,
   mpfb_rsp_if  rsp_chan,
   output int   error_count,
   output int   results_due,
   output int   results_seen,
   output int   reads_seen
);
   import mpfb_pkg::*;

   logic [7:0] page_bytes [PAGE_COUNT][DISPLAY_WIDTH];
   logic       pixel_values_due [$];
   int         errors;
   int         seen;
   int         reads;

   function automatic void plot(logic [7:0] px, logic [7:0] py, logic ink_bit);
      if (px < DISPLAY_WIDTH && py < DISPLAY_HEIGHT)
         page_bytes[py >> 3][px][py[2:0]] = ink_bit;
   endfunction

   function automatic logic pixel_at(logic [7:0] px, logic [7:0] py);
      if (px < DISPLAY_WIDTH && py < DISPLAY_HEIGHT)
         return page_bytes[py >> 3][px][py[2:0]];
      return 1'b0;
   endfunction

   function automatic void fill_span(logic [7:0] x0, logic [7:0] y0, logic [7:0] len,
                                     logic [7:0] thick, logic upright, logic ink_bit);
      for (int i = 0; i < len; i++)
         for (int j = 0; j < thick; j++)
            if (upright)
               plot(x0 + 8'(j), y0 + 8'(i), ink_bit);
            else
               plot(x0 + 8'(i), y0 + 8'(j), ink_bit);
   endfunction

   function automatic void draw_outline(draw_cmd_type c);
      fill_span(c.x, c.y, c.w, 8'd1, 1'b0, c.ink);
      fill_span(c.x, c.y + c.h - 8'd1, c.w, 8'd1, 1'b0, c.ink);
      fill_span(c.x, c.y + 8'd1, c.h - 8'd2, 8'd1, 1'b1, c.ink);
      fill_span(c.x + c.w - 8'd1, c.y + 8'd1, c.h - 8'd2, 8'd1, 1'b1, c.ink);
   endfunction

   function automatic void draw_rounded(draw_cmd_type c);
      logic corner;
      corner = c.erase ? c.ink : ~c.ink;
      fill_span(c.x, c.y, c.w, ROUND_THICK, 1'b0, c.ink);
      fill_span(c.x, c.y + c.h - ROUND_THICK, c.w, ROUND_THICK, 1'b0, c.ink);
      fill_span(c.x, c.y + ROUND_THICK, c.h - 8'd4, ROUND_THICK, 1'b1, c.ink);
      fill_span(c.x + c.w - ROUND_THICK, c.y + ROUND_THICK, c.h - 8'd4, ROUND_THICK,
                1'b1, c.ink);
      // Each corner: three outer pixels take the corner value, one inner pixel takes ink.
      plot(c.x, c.y, corner);
      plot(c.x + 8'd1, c.y, corner);
      plot(c.x, c.y + 8'd1, corner);
      plot(c.x + 8'd2, c.y + 8'd2, c.ink);
      plot(c.x + c.w - 8'd1, c.y, corner);
      plot(c.x + c.w - 8'd2, c.y, corner);
      plot(c.x + c.w - 8'd1, c.y + 8'd1, corner);
      plot(c.x + c.w - 8'd3, c.y + 8'd2, c.ink);
      plot(c.x + c.w - 8'd1, c.y + c.h - 8'd1, corner);
      plot(c.x + c.w - 8'd2, c.y + c.h - 8'd1, corner);
      plot(c.x + c.w - 8'd1, c.y + c.h - 8'd2, corner);
      plot(c.x + c.w - 8'd3, c.y + c.h - 8'd3, c.ink);
      plot(c.x, c.y + c.h - 8'd1, corner);
      plot(c.x + 8'd1, c.y + c.h - 8'd1, corner);
      plot(c.x, c.y + c.h - 8'd2, corner);
      plot(c.x + 8'd2, c.y + c.h - 8'd3, c.ink);
   endfunction

   function automatic logic apply_draw(draw_cmd_type c);
      logic pixel;
      pixel = 1'b0;
      case (c.code)
         CMD_SET:   plot(c.x, c.y, c.ink);
         CMD_GET:   pixel = pixel_at(c.x, c.y);
         CMD_HLINE: fill_span(c.x, c.y, c.w, c.h, 1'b0, c.ink);
         CMD_VLINE: fill_span(c.x, c.y, c.w, c.h, 1'b1, c.ink);
         CMD_RECT:  draw_outline(c);
         CMD_ROUND: draw_rounded(c);
         default:   pixel = 1'b0;
      endcase
      return pixel;
   endfunction

   always @(posedge clock) begin : track
      draw_cmd_type beat;
      logic         want;
      if (reset) begin
         foreach (page_bytes[p, c])
            page_bytes[p][c] = '0;
         pixel_values_due.delete();
         errors = 0;
         seen   = 0;
         reads  = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen++;
            if (pixel_values_due.size() == 0) begin
               $error("pixel_value: expected no beat, actual %0b", rsp_chan.pixel_value);
               errors++;
            end else begin
               want = pixel_values_due.pop_front();
               if (rsp_chan.pixel_value !== want) begin
                  $error("pixel_value: expected %0b, actual %0b", want, rsp_chan.pixel_value);
                  errors++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            beat.code  = req_chan.req_type;
            beat.x     = req_chan.x_pos;
            beat.y     = req_chan.y_pos;
            beat.w     = req_chan.span_main;
            beat.h     = req_chan.span_cross;
            beat.ink   = req_chan.ink;
            beat.erase = req_chan.corner_erase;
            if (beat.code == CMD_GET)
               reads++;
            pixel_values_due.push_back(apply_draw(beat));
         end
      end
      error_count  <= errors;
      results_due  <= pixel_values_due.size();
      results_seen <= seen;
      reads_seen   <= reads;
   end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Framebuffer draw unit testbench
// Resets the draw unit, sends a directed set of commands and then a long
// random mix of shapes and pixel reads, with random gaps on both channels, a
// long response stall and a full drain. The checker predicts every response.
// ----------------------------------------------------------------------------
module testbench;
   import mpfb_pkg::*;

   localparam int         RESET_CYCLES    = 11;
   localparam int         IDLE_LIMIT      = 40000;
   localparam int         RSP_HOLD_CYCLES = 1500;
   localparam int         DRAIN_CYCLES    = 40;
   localparam int         ITEM_TARGET     = 1650;
   localparam logic [2:0] CMD_SPARE_LO    = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI    = 3'd7;

   logic clock;
   logic reset;
   int   error_count;
   int   results_due;
   int   results_seen;
   int   reads_seen;
   int   items_sent;
   int   idle_cycles;
   bit   no_gaps;
   bit   rsp_hold_armed;
   bit   rsp_hold_active;

   mpfb_req_if req_chan ();
   mpfb_rsp_if rsp_chan ();

   mono_page_framebuffer_draw_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   draw_result_checker result_check (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .error_count  (error_count),
      .results_due  (results_due),
      .results_seen (results_seen),
      .reads_seen   (reads_seen)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 96)
         return $urandom_range(4, 15);
      return $urandom_range(30, 150);
   endfunction

   // The response side runs in stretches of ready followed by stalls, and
   // takes one long stall when the stimulus arms it.
   initial begin : rsp_pacing
      int unsigned run;
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold_armed) begin
            rsp_hold_armed  = 1'b0;
            rsp_hold_active = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
            rsp_hold_active = 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
            run = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 8) : $urandom_range(50, 300);
            repeat (run) @(posedge clock);
            gap = pick_gap();
            if (gap != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap - 1) @(posedge clock);
            end
         end
      end
   end

   function automatic draw_cmd_type draw_cmd(logic [2:0] code, logic [7:0] x, logic [7:0] y,
                                             logic [7:0] w, logic [7:0] h, logic ink,
                                             logic erase);
      draw_cmd_type c;
      c.code  = code;
      c.x     = x;
      c.y     = y;
      c.w     = w;
      c.h     = h;
      c.ink   = ink;
      c.erase = erase;
      return c;
   endfunction

   task automatic offer(draw_cmd_type c);
      req_chan.valid        <= 1'b1;
      req_chan.req_type     <= c.code;
      req_chan.x_pos        <= c.x;
      req_chan.y_pos        <= c.y;
      req_chan.span_main    <= c.w;
      req_chan.span_cross   <= c.h;
      req_chan.ink          <= c.ink;
      req_chan.corner_erase <= c.erase;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   task automatic send(draw_cmd_type c);
      int unsigned gap;
      offer(c);
      gap = no_gaps ? 0 : pick_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
   endtask

   function automatic draw_cmd_type random_shape(int unsigned size_max);
      logic [2:0] code;
      case ($urandom_range(0, 4))
         0:       code = CMD_HLINE;
         1:       code = CMD_VLINE;
         2:       code = CMD_RECT;
         3:       code = CMD_ROUND;
         default: code = CMD_SET;
      endcase
      return draw_cmd(code, 8'($urandom_range(0, 135)), 8'($urandom_range(0, 70)),
                      8'($urandom_range(0, size_max)), 8'($urandom_range(0, size_max)),
                      1'($urandom_range(0, 99) < 65), 1'($urandom));
   endfunction

   task automatic probe_shape(draw_cmd_type s);
      repeat ($urandom_range(1, 3))
         send(draw_cmd(CMD_GET, s.x + 8'($urandom_range(0, s.w + 2)),
                       s.y + 8'($urandom_range(0, s.h + 2)), 8'($urandom), 8'($urandom),
                       1'($urandom), 1'($urandom)));
   endtask

   task automatic run_directed();
      send(draw_cmd(CMD_GET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_SET, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b1));
      send(draw_cmd(CMD_SET, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd127, 8'd63, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_SET, 8'd128, 8'd64, 8'd0, 8'd0, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_HLINE, 8'd250, 8'd10, 8'd12, 8'd3, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd3, 8'd11, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_VLINE, 8'd5, 8'd60, 8'd10, 8'd2, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd6, 8'd2, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_HLINE, 8'd20, 8'd20, 8'd0, 8'd5, 1'b1, 1'b0));
      send(draw_cmd(CMD_VLINE, 8'd20, 8'd20, 8'd5, 8'd0, 1'b1, 1'b0));
      send(draw_cmd(CMD_HLINE, 8'd0, 8'd0, 8'd255, 8'd1, 1'b0, 1'b1));
      send(draw_cmd(CMD_VLINE, 8'd64, 8'd40, 8'd1, 8'd255, 1'b1, 1'b0));
      send(draw_cmd(CMD_RECT, 8'd10, 8'd20, 8'd20, 8'd12, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd10, 8'd25, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_RECT, 8'd30, 8'd5, 8'd1, 8'd0, 1'b1, 1'b0));
      send(draw_cmd(CMD_ROUND, 8'd40, 8'd30, 8'd16, 8'd12, 1'b1, 1'b0));
      send(draw_cmd(CMD_GET, 8'd40, 8'd30, 8'd0, 8'd0, 1'b0, 1'b0));
      send(draw_cmd(CMD_ROUND, 8'd90, 8'd40, 8'd3, 8'd2, 1'b0, 1'b1));
      send(draw_cmd(CMD_ROUND, 8'd0, 8'd0, 8'd255, 8'd255, 1'b1, 1'b0));
      send(draw_cmd(CMD_RECT, 8'd100, 8'd50, 8'd255, 8'd255, 1'b0, 1'b1));
      send(draw_cmd(CMD_SPARE_LO, 8'd1, 8'd1, 8'd4, 8'd4, 1'b1, 1'b1));
      send(draw_cmd(CMD_SPARE_HI, 8'd2, 8'd2, 8'd4, 8'd4, 1'b1, 1'b0));
   endtask

   task automatic run_random();
      draw_cmd_type s;
      int unsigned  pick;
      bit           held;
      bit           paused;
      held   = 1'b0;
      paused = 1'b0;
      while (items_sent < ITEM_TARGET) begin
         no_gaps = (items_sent % 300) < 40;
         if (!held && items_sent >= 600) begin
            // Stall the response side and keep offering beats until the stall ends.
            held = 1'b1;
            req_chan.valid <= 1'b0;
            rsp_hold_armed = 1'b1;
            while (!rsp_hold_active) @(posedge clock);
            no_gaps = 1'b1;
            while (rsp_hold_active)
               send(random_shape(4));
            no_gaps = 1'b0;
         end
         if (!paused && items_sent >= 1100) begin
            paused = 1'b1;
            wait_drained();
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            s = random_shape(10);
            send(s);
            probe_shape(s);
         end else if (pick < 70) begin
            send(draw_cmd(($urandom_range(0, 1) != 0) ? CMD_SET : CMD_GET,
                          8'($urandom_range(0, 127)), 8'($urandom_range(0, 63)),
                          8'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)));
         end else if (pick < 78) begin
            s = draw_cmd(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom), 8'd0, 8'd0,
                         1'($urandom), 1'($urandom));
            if ($urandom_range(0, 1) != 0) begin
               s.w = 8'($urandom_range(0, 255));
               s.h = 8'($urandom_range(0, 3));
            end else begin
               s.w = 8'($urandom_range(0, 3));
               s.h = 8'($urandom_range(0, 255));
            end
            send(s);
         end else if (pick < 88) begin
            s = random_shape(5);
            s.x = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(120, 135))
                                              : 8'($urandom_range(250, 255));
            s.y = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(58, 70))
                                              : 8'($urandom_range(250, 255));
            send(s);
            probe_shape(s);
         end else begin
            send(draw_cmd(3'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                          8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                          1'($urandom), 1'($urandom)));
         end
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.req_type     <= CMD_SET;
      req_chan.x_pos        <= '0;
      req_chan.y_pos        <= '0;
      req_chan.span_main    <= '0;
      req_chan.span_cross   <= '0;
      req_chan.ink          <= 1'b0;
      req_chan.corner_erase <= 1'b0;
      items_sent      = 0;
      no_gaps         = 1'b0;
      rsp_hold_armed  = 1'b0;
      rsp_hold_active = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      wait_drained();
      run_random();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d commands (lines, outlines, rounded shapes, clipped and wrapped spans);",
               items_sent);
      $display("compared %0d response beats, %0d of them pixel reads, across stalls and drains.",
               results_seen, reads_seen);
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/mpfb_pkg.sv
hdl/mpfb_ifs.sv
hdl/mpfb_datapath.sv
hdl/mpfb_controller.sv
hdl/mono_page_framebuffer_draw_unit.sv
hdl/mpfb_checker.sv
bench/draw_result_checker.sv
bench/testbench.sv
